>>> rtl/fpbn_pkg.sv
// ----------------------------------------------------------------------------
// fpbn_pkg
// Shared types and constants of the fixed-point batch normalization block.
// ----------------------------------------------------------------------------
package fpbn_pkg;

    localparam int CHANNELS_DEF = 64;
    localparam int DATA_WIDTH   = 16;
    localparam int SAMPLE_W     = 16;
    localparam int CH_W         = 6;
    localparam int FRAC_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CNT_W        = 32;
    localparam int ENTRY_W      = 4 * SAMPLE_W;
    localparam int QUEUE_DEPTH  = 4;
    localparam int SUM_W        = 66;

    localparam logic [FRAC_W-1:0] FRAC_RESET = 4'd8;

    localparam logic signed [SUM_W-1:0] SAT_MAX =
        $signed((66'd1 << (DATA_WIDTH - 1)) - 66'd1);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - 66'sd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_FRAC  = 2'd0,
        CFG_W_FRAC   = 2'd1,
        CFG_OUT_FRAC = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [FRAC_W-1:0] in_frac;
        logic [FRAC_W-1:0] w_frac;
        logic [FRAC_W-1:0] out_frac;
    } t_cfg;

    typedef struct packed {
        logic                       smp;
        logic                       in_range;
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [SAMPLE_W-1:0] mean;
        logic signed [SAMPLE_W-1:0] inv_dev;
        logic signed [SAMPLE_W-1:0] gamma;
        logic signed [SAMPLE_W-1:0] beta;
    } t_cmd;

endpackage

>>> rtl/fpbn_ram.sv
// ----------------------------------------------------------------------------
// fpbn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpbn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fpbn_front.sv
// ----------------------------------------------------------------------------
// fpbn_front
// Accepts items, classifies them (write or sample, channel in range) and
// queues them for the back end.
// ----------------------------------------------------------------------------
module fpbn_front
    import fpbn_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_opcode,
    input  logic [CH_W-1:0]            i_channel,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [SAMPLE_W-1:0] i_mean_in,
    input  logic signed [SAMPLE_W-1:0] i_inv_dev_in,
    input  logic signed [SAMPLE_W-1:0] i_gamma_in,
    input  logic signed [SAMPLE_W-1:0] i_beta_in,
    input  logic                       i_pop,
    output logic                       o_head_valid,
    output t_cmd                       o_head
);

    localparam int QP_W = $clog2(QUEUE_DEPTH);

    t_cmd            r_q [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QP_W:0]   r_count;
    logic [QP_W:0]   n_count;
    logic            push;
    logic            pop;
    t_cmd            cmd;

    assign o_in_stall   = (r_count == (QP_W + 1)'(QUEUE_DEPTH));
    assign push         = i_in_valid && !o_in_stall;
    assign pop          = i_pop && (r_count != '0);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_q[r_rd_ptr];

    always_comb begin
        cmd.smp      = (t_opcode'(i_opcode) == OP_SAMPLE);
        cmd.in_range = (32'(i_channel) < 32'(CHANNELS));
        cmd.channel  = i_channel;
        cmd.sample   = i_sample;
        cmd.mean     = i_mean_in;
        cmd.inv_dev  = i_inv_dev_in;
        cmd.gamma    = i_gamma_in;
        cmd.beta     = i_beta_in;
    end

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

endmodule

>>> rtl/fpbn_back.sv
// ----------------------------------------------------------------------------
// fpbn_back
// Coefficient table plus a six-stage normalize pipeline, saturation counter
// and output register.
// ----------------------------------------------------------------------------
module fpbn_back
    import fpbn_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_head_valid,
    input  t_cmd                       i_head,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_result_value,
    output logic                       o_saturated,
    output logic [CNT_W-1:0]           o_overflow_count
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic signed [63:0] NCLAMP     = 64'sd1 <<< 47;
    localparam logic signed [63:0] NCLAMP_NEG = -NCLAMP;

    logic en;
    logic pop;

    // stage registers
    logic r_s1_valid, r_s1_smp, r_s1_in_range;
    logic signed [SAMPLE_W-1:0] r_s1_sample;
    logic r_s2_valid, r_s2_smp;
    logic signed [31:0] r_s2_diff;
    logic signed [SAMPLE_W-1:0] r_s2_inv, r_s2_gamma;
    logic signed [30:0] r_s2_b;
    logic r_s3_valid, r_s3_smp;
    logic signed [47:0] r_s3_norm;
    logic signed [SAMPLE_W-1:0] r_s3_gamma;
    logic signed [30:0] r_s3_b;
    logic r_s4_valid, r_s4_smp;
    logic signed [48:0] r_s4_norm;
    logic signed [SAMPLE_W-1:0] r_s4_gamma;
    logic signed [30:0] r_s4_b;
    logic r_s5_valid, r_s5_smp;
    logic signed [40:0] r_s5_hi_p, r_s5_lo_p;
    logic signed [30:0] r_s5_b;
    logic r_s6_valid, r_s6_smp;
    logic signed [64:0] r_s6_g;
    logic signed [30:0] r_s6_b;
    logic r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_value;
    logic r_out_sat;
    logic [CNT_W-1:0] r_out_cnt;
    logic [CNT_W-1:0] r_cnt;

    logic [ENTRY_W-1:0] ram_rdata;

    assign en    = !r_out_valid || !i_out_stall;
    assign pop   = en && i_head_valid;
    assign o_pop = pop;

    fpbn_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (pop && !i_head.smp && i_head.in_range),
        .i_waddr (AW'(i_head.channel)),
        .i_wdata ({i_head.beta, i_head.gamma, i_head.inv_dev, i_head.mean}),
        .i_re    (pop),
        .i_raddr (AW'(i_head.channel)),
        .o_rdata (ram_rdata)
    );

    // S1: mean alignment, difference, beta alignment
    logic [ENTRY_W-1:0]         s1_entry;
    logic signed [SAMPLE_W-1:0] s1_mean, s1_inv, s1_gamma, s1_beta;
    logic [4:0]                 s1_msh, s1_mneg, s1_bsh, s1_bneg;
    logic signed [30:0]         s1_mean_x, s1_beta_x, s1_mean_adj, s1_b;
    logic signed [31:0]         s1_samp32, s1_madj32, s1_diff;

    assign s1_entry  = r_s1_in_range ? ram_rdata : '0;
    assign s1_mean   = s1_entry[15:0];
    assign s1_inv    = s1_entry[31:16];
    assign s1_gamma  = s1_entry[47:32];
    assign s1_beta   = s1_entry[63:48];
    assign s1_msh    = {1'b0, i_cfg.in_frac} - {1'b0, i_cfg.w_frac};
    assign s1_mneg   = 5'd0 - s1_msh;
    assign s1_bsh    = {1'b0, i_cfg.w_frac} - {1'b0, i_cfg.out_frac};
    assign s1_bneg   = 5'd0 - s1_bsh;
    assign s1_mean_x = {{15{s1_mean[15]}}, s1_mean};
    assign s1_beta_x = {{15{s1_beta[15]}}, s1_beta};
    assign s1_mean_adj = s1_msh[4] ? (s1_mean_x <<< s1_mneg[3:0])
                                   : (s1_mean_x >>> s1_msh[3:0]);
    assign s1_b      = s1_bsh[4] ? (s1_beta_x <<< s1_bneg[3:0])
                                 : (s1_beta_x >>> s1_bsh[3:0]);
    assign s1_samp32 = {{16{r_s1_sample[15]}}, r_s1_sample};
    assign s1_madj32 = {s1_mean_adj[30], s1_mean_adj};
    assign s1_diff   = s1_samp32 - s1_madj32;

    // S2: scale by inverse deviation
    logic signed [47:0] s2_diff48, s2_inv48, s2_norm;

    assign s2_diff48 = {{16{r_s2_diff[31]}}, r_s2_diff};
    assign s2_inv48  = {{32{r_s2_inv[15]}}, r_s2_inv};
    assign s2_norm   = s2_diff48 * s2_inv48;

    // S3: output alignment, left shifts clamped to +/-2^47
    logic [6:0]         s3_sh, s3_neg;
    logic signed [47:0] s3_right;
    logic signed [63:0] s3_wide;
    logic signed [48:0] s3_norm;

    assign s3_sh    = 7'({3'b0, i_cfg.in_frac}) + 7'({3'b0, i_cfg.w_frac})
                    - 7'({3'b0, i_cfg.out_frac});
    assign s3_neg   = 7'd0 - s3_sh;
    assign s3_right = r_s3_norm >>> s3_sh[4:0];
    assign s3_wide  = {{16{r_s3_norm[47]}}, r_s3_norm} <<< s3_neg[3:0];

    always_comb begin
        priority if (!s3_sh[6]) begin
            s3_norm = {s3_right[47], s3_right};
        end else if (s3_wide > NCLAMP) begin
            s3_norm = NCLAMP[48:0];
        end else if (s3_wide < NCLAMP_NEG) begin
            s3_norm = NCLAMP_NEG[48:0];
        end else begin
            s3_norm = s3_wide[48:0];
        end
    end

    // S4: gamma multiply as two partial products
    logic signed [40:0] s4_hi41, s4_lo41, s4_g41;

    assign s4_hi41 = {{16{r_s4_norm[48]}}, r_s4_norm[48:24]};
    assign s4_lo41 = {17'd0, r_s4_norm[23:0]};
    assign s4_g41  = {{25{r_s4_gamma[15]}}, r_s4_gamma};

    // S5: combine partial products, drop weight fraction bits
    logic signed [64:0] s5_prod, s5_g;

    assign s5_prod = ({{24{r_s5_hi_p[40]}}, r_s5_hi_p} <<< 24)
                   + {{24{r_s5_lo_p[40]}}, r_s5_lo_p};
    assign s5_g    = s5_prod >>> i_cfg.w_frac;

    // S6: beta add and saturation
    logic signed [SUM_W-1:0]    s6_sum;
    logic                       s6_hi, s6_lo, s6_sat;
    logic signed [SAMPLE_W-1:0] s6_value;

    assign s6_sum = {r_s6_g[64], r_s6_g} + {{35{r_s6_b[30]}}, r_s6_b};
    assign s6_hi  = (s6_sum > SAT_MAX);
    assign s6_lo  = (s6_sum < SAT_MIN);
    assign s6_sat = r_s6_smp && (s6_hi || s6_lo);

    always_comb begin
        priority if (!r_s6_smp) begin
            s6_value = '0;
        end else if (s6_hi) begin
            s6_value = SAT_MAX[SAMPLE_W-1:0];
        end else if (s6_lo) begin
            s6_value = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            s6_value = s6_sum[SAMPLE_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_s6_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else if (en) begin
            r_s1_valid  <= pop;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_s5_valid  <= r_s4_valid;
            r_s6_valid  <= r_s5_valid;
            r_out_valid <= r_s6_valid;
            if (r_s6_valid && s6_sat) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_smp      <= i_head.smp;
            r_s1_in_range <= i_head.in_range;
            r_s1_sample   <= i_head.sample;

            r_s2_smp   <= r_s1_smp;
            r_s2_diff  <= s1_diff;
            r_s2_inv   <= s1_inv;
            r_s2_gamma <= s1_gamma;
            r_s2_b     <= s1_b;

            r_s3_smp   <= r_s2_smp;
            r_s3_norm  <= s2_norm;
            r_s3_gamma <= r_s2_gamma;
            r_s3_b     <= r_s2_b;

            r_s4_smp   <= r_s3_smp;
            r_s4_norm  <= s3_norm;
            r_s4_gamma <= r_s3_gamma;
            r_s4_b     <= r_s3_b;

            r_s5_smp  <= r_s4_smp;
            r_s5_hi_p <= s4_hi41 * s4_g41;
            r_s5_lo_p <= s4_lo41 * s4_g41;
            r_s5_b    <= r_s4_b;

            r_s6_smp <= r_s5_smp;
            r_s6_g   <= s5_g;
            r_s6_b   <= r_s5_b;

            if (r_s6_valid) begin
                r_out_value <= s6_value;
                r_out_sat   <= s6_sat;
                r_out_cnt   <= r_cnt + CNT_W'(s6_sat);
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_value   = r_out_value;
    assign o_saturated      = r_out_sat;
    assign o_overflow_count = r_out_cnt;

endmodule

>>> rtl/fixed_point_batch_norm.sv
// ----------------------------------------------------------------------------
// fixed_point_batch_norm
// Per-channel fixed-point batch normalization with a coefficient table.
// An accepted item passes the queue hop, table read, arithmetic stages and
// output register before its result is valid.
// Throughput: one item per cycle, set by one table access per item and a
// fully pipelined datapath; an output stall freezes the pipeline.
// Reset: queue, pipeline and saturation count cleared, fraction registers 8;
// the coefficient table is undefined until written.
// ----------------------------------------------------------------------------
module fixed_point_batch_norm
    import fpbn_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [FRAC_W-1:0]          i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_opcode,
    input  logic [CH_W-1:0]            i_channel,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [SAMPLE_W-1:0] i_mean_in,
    input  logic signed [SAMPLE_W-1:0] i_inv_dev_in,
    input  logic signed [SAMPLE_W-1:0] i_gamma_in,
    input  logic signed [SAMPLE_W-1:0] i_beta_in,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_result_value,
    output logic                       o_saturated,
    output logic [CNT_W-1:0]           o_overflow_count
);

    t_cfg r_cfg;
    logic head_valid;
    t_cmd head;
    logic pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_frac  <= FRAC_RESET;
            r_cfg.w_frac   <= FRAC_RESET;
            r_cfg.out_frac <= FRAC_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IN_FRAC:  r_cfg.in_frac  <= i_cfg_data;
                CFG_W_FRAC:   r_cfg.w_frac   <= i_cfg_data;
                CFG_OUT_FRAC: r_cfg.out_frac <= i_cfg_data;
                default: ;
            endcase
        end
    end

    fpbn_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_channel    (i_channel),
        .i_sample     (i_sample),
        .i_mean_in    (i_mean_in),
        .i_inv_dev_in (i_inv_dev_in),
        .i_gamma_in   (i_gamma_in),
        .i_beta_in    (i_beta_in),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    fpbn_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_head_valid     (head_valid),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_value   (o_result_value),
        .o_saturated      (o_saturated),
        .o_overflow_count (o_overflow_count)
    );

endmodule
